// ----- hw/rtl/incremental_lq_tracking_controller_macros.svh -----
// assertion macros for the incremental lq tracking controller
`ifndef INCREMENTAL_LQ_TRACKING_CONTROLLER_MACROS_SVH
`define INCREMENTAL_LQ_TRACKING_CONTROLLER_MACROS_SVH

// property checked on every rising edge outside reset
`define ILTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define ILTC_ASSERT_IMPL(label, ante, cons, msg) \
  `ILTC_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ILTC_ASSERT_NEXT(label, ante, cons, msg) \
  `ILTC_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- hw/rtl/iltc_pkg.sv -----
// shared constants and types of the incremental lq tracking controller
package iltc_pkg;

  localparam int FIELD_W   = 32;
  localparam int STEP_W    = 31;
  localparam int CFG_IDX_W = 3;
  localparam int DIGIT_W   = 4;
  localparam int NUM_REF   = 4;
  localparam int TERM_W    = 3;
  localparam int WT_SCALE  = 10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT      = 3'd0,
    REG_STEP_SIZE     = 3'd1,
    REG_GAIN_POSITION = 3'd2,
    REG_GAIN_VELOCITY = 3'd3,
    REG_GAIN_INTEGRAL = 3'd4
  } cfg_reg_e;

  typedef enum logic [TERM_W-1:0] {
    TERM_MU       = 3'd0,
    TERM_INTEGRAL = 3'd1,
    TERM_POSITION = 3'd2,
    TERM_VELOCITY = 3'd3,
    TERM_REF0     = 3'd4,
    TERM_REF1     = 3'd5,
    TERM_REF2     = 3'd6,
    TERM_REF3     = 3'd7
  } term_e;

  localparam logic signed [FIELD_W-1:0] SETPOINT_RST      = 32'sd131072;
  localparam logic        [STEP_W-1:0]  STEP_SIZE_RST     = 31'd1311;
  localparam logic signed [FIELD_W-1:0] GAIN_POSITION_RST = 32'sd247936;
  localparam logic signed [FIELD_W-1:0] GAIN_VELOCITY_RST = 32'sd89902;
  localparam logic signed [FIELD_W-1:0] GAIN_INTEGRAL_RST = -32'sd215960;

  // reference weights in units of 1/10000
  localparam int WT_X [NUM_REF] = '{-4564, 77, -95, 1};
  localparam int WT_Y [NUM_REF] = '{156, 139, 7, 6};

endpackage

// ----- hw/rtl/incremental_lq_tracking_controller.sv -----
// two-axis incremental lq tracking controller with digit-serial multiplier
// A tick with position_seen high yields one beat of saturated x/y commands; a tick
// with position_seen low yields nothing and leaves the state alone.
// All products run through one shared signed multiplier that consumes DIGIT_W
// multiplier bits per cycle, eight products per axis, each taking a load step,
// one digit step per DIGIT_W-bit digit of the multiplier and an accumulate step;
// after the eight products of an axis a command step follows, and the y command
// step waits for the previous result beat to be taken. A new tick is accepted
// only while the controller is idle; a finished result waits in the output
// register while the next tick is already being worked on.
`include "incremental_lq_tracking_controller_macros.svh"

module incremental_lq_tracking_controller
  import iltc_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [FIELD_W-1:0]        cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      position_seen_i,
  input  logic signed [FIELD_W-1:0] pos_x_i,
  input  logic signed [FIELD_W-1:0] pos_y_i,
  input  logic signed [FIELD_W-1:0] vel_x_i,
  input  logic signed [FIELD_W-1:0] vel_y_i,
  input  logic signed [FIELD_W-1:0] ref_0_i,
  input  logic signed [FIELD_W-1:0] ref_1_i,
  input  logic signed [FIELD_W-1:0] ref_2_i,
  input  logic signed [FIELD_W-1:0] ref_3_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [FIELD_W-1:0] cmd_x_o,
  output logic signed [FIELD_W-1:0] cmd_y_o
);

  localparam int IW   = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
  localparam int XW   = IW + 4;
  localparam int NDIG = (DATA_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int ND   = NDIG * DIGIT_W;
  localparam int AW   = DATA_WIDTH + DIGIT_W + 1;
  localparam int PW   = AW + ND;
  localparam int DCW  = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int SW   = DATA_WIDTH + 3;

  typedef logic signed [DATA_WIDTH-1:0] val_t;
  typedef logic signed [XW-1:0]         wide_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_CMD
  } state_e;

  localparam wide_t VMAX = {{(XW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam wide_t VMIN = ~VMAX;

  function automatic val_t sat_w(input wide_t v);
    val_t r;
    if (v > VMAX) begin
      r = VMAX[DATA_WIDTH-1:0];
    end else if (v < VMIN) begin
      r = VMIN[DATA_WIDTH-1:0];
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic val_t weight_q(input int w);
    longint m;
    longint q;
    longint lim;
    m   = (w < 0) ? -longint'(w) : longint'(w);
    q   = ((m <<< FRAC_BITS) + WT_SCALE / 2) / WT_SCALE;
    lim = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    if (w < 0) begin
      if (q > lim + 1) q = lim + 1;
      return DATA_WIDTH'(-q);
    end
    if (q > lim) q = lim;
    return DATA_WIDTH'(q);
  endfunction

  function automatic logic signed [FIELD_W-1:0] to_field(input val_t v);
    wide_t t;
    t = wide_t'(v);
    return t[FIELD_W-1:0];
  endfunction

  localparam val_t WQ_X [NUM_REF] = '{weight_q(WT_X[0]), weight_q(WT_X[1]),
                                      weight_q(WT_X[2]), weight_q(WT_X[3])};
  localparam val_t WQ_Y [NUM_REF] = '{weight_q(WT_Y[0]), weight_q(WT_Y[1]),
                                      weight_q(WT_Y[2]), weight_q(WT_Y[3])};

  state_e                      state_q;
  logic                        axis_q;
  term_e                       term_q;
  logic [DCW-1:0]              digit_q;
  logic                        out_valid_q;
  logic signed [FIELD_W-1:0]   cmd_x_q, cmd_y_q;

  logic signed [FIELD_W-1:0]   setpoint_q, gain_position_q, gain_velocity_q, gain_integral_q;
  logic        [STEP_W-1:0]    step_size_q;

  logic signed [FIELD_W-1:0]   last_pos_x_q, last_pos_y_q, last_vel_x_q, last_vel_y_q;
  val_t                        last_cmd_x_q, last_cmd_y_q;

  logic signed [FIELD_W-1:0]   pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic signed [FIELD_W-1:0]   ref_q [NUM_REF];

  val_t                        mcand_q;
  logic        [ND-1:0]        mplier_q;
  logic signed [AW-1:0]        acc_q, acc_d;
  logic        [ND-1:0]        lo_q, lo_d;
  val_t                        mu_q;
  logic signed [SW-1:0]        sum_q;

  logic                        in_fire;
  logic                        last_digit;
  logic signed [FIELD_W-1:0]   cur_pos, cur_vel, prev_pos, prev_vel, cur_ref;
  val_t                        prev_cmd, setp_v, op_a, op_b;
  logic signed [DIGIT_W:0]     dig;
  logic signed [AW-1:0]        pp, mac;
  logic signed [PW-1:0]        prod, prod_sh;
  val_t                        term_v, neg_s, cmd_v;
  logic                        out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign cmd_x_o     = cmd_x_q;
  assign cmd_y_o     = cmd_y_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign last_digit  = (digit_q == DCW'(NDIG - 1));

  // operand selection
  always_comb begin
    cur_pos  = axis_q ? pos_y_q : pos_x_q;
    cur_vel  = axis_q ? vel_y_q : vel_x_q;
    prev_pos = axis_q ? last_pos_y_q : last_pos_x_q;
    prev_vel = axis_q ? last_vel_y_q : last_vel_x_q;
    prev_cmd = axis_q ? last_cmd_y_q : last_cmd_x_q;
    cur_ref  = ref_q[term_q[1:0]];
    setp_v   = sat_w(wide_t'(setpoint_q));
    case (term_q)
      TERM_MU: begin
        op_a = sat_w(wide_t'($signed({1'b0, step_size_q})));
        op_b = sat_w(wide_t'(setp_v) - wide_t'(prev_pos));
      end
      TERM_INTEGRAL: begin
        op_a = sat_w(wide_t'(gain_integral_q));
        op_b = mu_q;
      end
      TERM_POSITION: begin
        op_a = sat_w(wide_t'(gain_position_q));
        op_b = sat_w(wide_t'(cur_pos) - wide_t'(prev_pos));
      end
      TERM_VELOCITY: begin
        op_a = sat_w(wide_t'(gain_velocity_q));
        op_b = sat_w(wide_t'(cur_vel) - wide_t'(prev_vel));
      end
      default: begin
        op_a = axis_q ? WQ_Y[term_q[1:0]] : WQ_X[term_q[1:0]];
        op_b = sat_w(wide_t'(cur_ref));
      end
    endcase
  end

  // one multiplier digit per cycle, top digit signed
  always_comb begin
    dig   = last_digit ? $signed({mplier_q[DIGIT_W-1], mplier_q[DIGIT_W-1:0]})
                       : $signed({1'b0, mplier_q[DIGIT_W-1:0]});
    pp    = AW'(mcand_q) * AW'(dig);
    mac   = acc_q + pp;
    acc_d = mac >>> DIGIT_W;
    lo_d  = {mac[DIGIT_W-1:0], lo_q[ND-1:DIGIT_W]};
  end

  // scale, floor and saturate the finished product
  always_comb begin
    prod    = {acc_q, lo_q};
    prod_sh = prod >>> FRAC_BITS;
    if ((&prod_sh[PW-1:DATA_WIDTH-1]) || !(|prod_sh[PW-1:DATA_WIDTH-1])) begin
      term_v = prod_sh[DATA_WIDTH-1:0];
    end else begin
      term_v = prod_sh[PW-1] ? VMIN[DATA_WIDTH-1:0] : VMAX[DATA_WIDTH-1:0];
    end
    neg_s = sat_w(-wide_t'(sum_q));
    cmd_v = sat_w(wide_t'(prev_cmd) + wide_t'(neg_s));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      axis_q          <= 1'b0;
      term_q          <= TERM_MU;
      digit_q         <= '0;
      out_valid_q     <= 1'b0;
      cmd_x_q         <= '0;
      cmd_y_q         <= '0;
      setpoint_q      <= SETPOINT_RST;
      step_size_q     <= STEP_SIZE_RST;
      gain_position_q <= GAIN_POSITION_RST;
      gain_velocity_q <= GAIN_VELOCITY_RST;
      gain_integral_q <= GAIN_INTEGRAL_RST;
      last_pos_x_q    <= '0;
      last_pos_y_q    <= '0;
      last_vel_x_q    <= '0;
      last_vel_y_q    <= '0;
      last_cmd_x_q    <= '0;
      last_cmd_y_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SETPOINT:      setpoint_q      <= cfg_data_i;
          REG_STEP_SIZE:     step_size_q     <= cfg_data_i[STEP_W-1:0];
          REG_GAIN_POSITION: gain_position_q <= cfg_data_i;
          REG_GAIN_VELOCITY: gain_velocity_q <= cfg_data_i;
          REG_GAIN_INTEGRAL: gain_integral_q <= cfg_data_i;
          default: ;
        endcase
      end
      // a y command step refills the output register itself
      if (out_valid_q && out_ready_i && !(state_q == ST_CMD && axis_q)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && position_seen_i) begin
            axis_q  <= 1'b0;
            term_q  <= TERM_MU;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          digit_q <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          digit_q <= digit_q + 1'b1;
          if (last_digit) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (term_q == TERM_REF3) begin
            state_q <= ST_CMD;
          end else begin
            term_q  <= term_e'(TERM_W'(term_q + 1'b1));
            state_q <= ST_LOAD;
          end
        end
        ST_CMD: begin
          if (!axis_q) begin
            last_pos_x_q <= pos_x_q;
            last_vel_x_q <= vel_x_q;
            last_cmd_x_q <= cmd_v;
            axis_q       <= 1'b1;
            term_q       <= TERM_MU;
            state_q      <= ST_LOAD;
          end else if (out_free) begin
            last_pos_y_q <= pos_y_q;
            last_vel_y_q <= vel_y_q;
            last_cmd_y_q <= cmd_v;
            cmd_x_q      <= to_field(last_cmd_x_q);
            cmd_y_q      <= to_field(cmd_v);
            out_valid_q  <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
      vel_x_q  <= vel_x_i;
      vel_y_q  <= vel_y_i;
      ref_q[0] <= ref_0_i;
      ref_q[1] <= ref_1_i;
      ref_q[2] <= ref_2_i;
      ref_q[3] <= ref_3_i;
      sum_q    <= '0;
    end
    case (state_q)
      ST_LOAD: begin
        mcand_q  <= op_a;
        mplier_q <= ND'(op_b);
        acc_q    <= '0;
      end
      ST_MUL: begin
        acc_q    <= acc_d;
        lo_q     <= lo_d;
        mplier_q <= mplier_q >> DIGIT_W;
      end
      ST_ACC: begin
        if (term_q == TERM_MU) begin
          mu_q <= term_v;
        end else begin
          sum_q <= sum_q + SW'(term_v);
        end
      end
      ST_CMD: begin
        if (!axis_q) begin
          sum_q <= '0;
        end
      end
      default: ;
    endcase
  end

  `ILTC_ASSERT_IMPL(a_result_from_y_cmd, $rose(out_valid_o),
                    $past(state_q) == ST_CMD && $past(axis_q),
                    "result beat not raised by y command step")
  `ILTC_ASSERT_NEXT(a_x_then_y, state_q == ST_CMD && !axis_q,
                    state_q == ST_LOAD && axis_q && term_q == TERM_MU,
                    "y axis did not follow x axis")
  `ILTC_ASSERT_NEXT(a_no_pos_keeps_state, in_fire && !position_seen_i,
                    state_q == ST_IDLE && $stable(last_cmd_x_q) && $stable(last_pos_y_q),
                    "tick without position changed state")

endmodule

// ----- verif/incremental_lq_tracking_controller_test.sv -----
// self-checking testbench for the two-axis incremental lq tracking controller
`timescale 1ns / 1ps

module incremental_lq_tracking_controller_test;
  import iltc_pkg::*;

  localparam int FRAC = 16;
  localparam int WT_DIV = 10000;
  localparam int DRAIN_CYCLES = 200;
  localparam int END_WAIT_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam logic signed [FIELD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [FIELD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] WORD_ONE = 32'sh0001_0000;
  localparam logic signed [FIELD_W-1:0] WORD_NEG_LSB = 32'shffff_ffff;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;
  localparam int X_REF_WT [NUM_REF] = '{-4564, 77, -95, 1};
  localparam int Y_REF_WT [NUM_REF] = '{156, 139, 7, 6};

  typedef enum int {SINK_OPEN, SINK_LOOSE, SINK_TIGHT, SINK_SHUT} sink_mode_e;

  typedef struct {
    logic                      seen;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
    logic signed [FIELD_W-1:0] ref_0;
    logic signed [FIELD_W-1:0] ref_1;
    logic signed [FIELD_W-1:0] ref_2;
    logic signed [FIELD_W-1:0] ref_3;
  } tick_t;

  typedef struct {
    logic signed [FIELD_W-1:0] cmd_x;
    logic signed [FIELD_W-1:0] cmd_y;
  } cmd_pair_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [FIELD_W-1:0]        cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      position_seen_i;
  logic signed [FIELD_W-1:0] pos_x_i;
  logic signed [FIELD_W-1:0] pos_y_i;
  logic signed [FIELD_W-1:0] vel_x_i;
  logic signed [FIELD_W-1:0] vel_y_i;
  logic signed [FIELD_W-1:0] ref_0_i;
  logic signed [FIELD_W-1:0] ref_1_i;
  logic signed [FIELD_W-1:0] ref_2_i;
  logic signed [FIELD_W-1:0] ref_3_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [FIELD_W-1:0] cmd_x_o;
  logic signed [FIELD_W-1:0] cmd_y_o;

  incremental_lq_tracking_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .position_seen_i (position_seen_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .vel_x_i         (vel_x_i),
    .vel_y_i         (vel_y_i),
    .ref_0_i         (ref_0_i),
    .ref_1_i         (ref_1_i),
    .ref_2_i         (ref_2_i),
    .ref_3_i         (ref_3_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cmd_x_o         (cmd_x_o),
    .cmd_y_o         (cmd_y_o)
  );

  // controller copy: settings and per-axis history
  longint setpoint_v, step_v, gain_pos_v, gain_vel_v, gain_int_v;
  longint prev_pos_x, prev_pos_y, prev_vel_x, prev_vel_y, prev_cmd_x, prev_cmd_y;

  cmd_pair_t   expected_cmds[$];
  int unsigned failures;
  int unsigned ticks_sent;
  int unsigned idle_ticks;
  int unsigned beats_checked;
  int unsigned settings_loaded;
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d command beats outstanding", expected_cmds.size());
    $display("simulation failed");
    $finish;
  end

  function automatic longint clamp_word(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint fixed_mul(input longint a, input longint b);
    return clamp_word((a * b) >>> FRAC);
  endfunction

  function automatic longint weight_fixed(input int w);
    longint mag;
    mag = (w < 0) ? -longint'(w) : longint'(w);
    mag = ((mag << FRAC) + WT_DIV / 2) / WT_DIV;
    return (w < 0) ? -mag : mag;
  endfunction

  function automatic longint next_axis_cmd(input longint pos, input longint vel,
                                           input longint last_pos, input longint last_vel,
                                           input longint last_cmd, input tick_t t,
                                           input bit y_axis);
    longint sum;
    longint refs [NUM_REF];
    refs[0] = t.ref_0;
    refs[1] = t.ref_1;
    refs[2] = t.ref_2;
    refs[3] = t.ref_3;
    sum = fixed_mul(gain_pos_v, clamp_word(pos - last_pos))
        + fixed_mul(gain_vel_v, clamp_word(vel - last_vel))
        + fixed_mul(gain_int_v, fixed_mul(step_v, clamp_word(setpoint_v - last_pos)));
    for (int i = 0; i < NUM_REF; i++) begin
      sum += fixed_mul(weight_fixed(y_axis ? Y_REF_WT[i] : X_REF_WT[i]), refs[i]);
    end
    return clamp_word(last_cmd + clamp_word(-sum));
  endfunction

  function automatic void advance_controller(input tick_t t);
    cmd_pair_t c;
    longint nx, ny;
    if (!t.seen) return;
    nx = next_axis_cmd(t.pos_x, t.vel_x, prev_pos_x, prev_vel_x, prev_cmd_x, t, 1'b0);
    ny = next_axis_cmd(t.pos_y, t.vel_y, prev_pos_y, prev_vel_y, prev_cmd_y, t, 1'b1);
    prev_pos_x = t.pos_x;
    prev_pos_y = t.pos_y;
    prev_vel_x = t.vel_x;
    prev_vel_y = t.vel_y;
    prev_cmd_x = nx;
    prev_cmd_y = ny;
    c.cmd_x = nx[FIELD_W-1:0];
    c.cmd_y = ny[FIELD_W-1:0];
    expected_cmds.push_back(c);
  endfunction

  function automatic tick_t make_tick(input logic seen,
                                      input logic signed [FIELD_W-1:0] px, py, vx, vy,
                                      input logic signed [FIELD_W-1:0] r0, r1, r2, r3);
    tick_t t;
    t.seen = seen;
    t.pos_x = px;
    t.pos_y = py;
    t.vel_x = vx;
    t.vel_y = vy;
    t.ref_0 = r0;
    t.ref_1 = r1;
    t.ref_2 = r2;
    t.ref_3 = r3;
    return t;
  endfunction

  function automatic tick_t flat_tick(input logic seen, input logic signed [FIELD_W-1:0] v);
    return make_tick(seen, v, v, v, v, v, v, v, v);
  endfunction

  function automatic logic signed [FIELD_W-1:0] span_word(input int bits);
    return $signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3, 4, 5: return span_word(20);
      default: return $urandom();
    endcase
  endfunction

  function automatic tick_t wild_tick(input logic seen);
    return make_tick(seen, pick_word(), pick_word(), pick_word(), pick_word(),
                     pick_word(), pick_word(), pick_word(), pick_word());
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_gain();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return span_word(20);
  endfunction

  task automatic note_mismatch(input string what, input logic signed [FIELD_W-1:0] want,
                               input logic signed [FIELD_W-1:0] got);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t: %s expected %0d (0x%08h) got %0d (0x%08h)",
               $realtime, what, want, want, got, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    cmd_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_cmds.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("%0t: unexpected command beat x=%0d y=%0d", $realtime, cmd_x_o, cmd_y_o);
        end
      end else begin
        want = expected_cmds.pop_front();
        beats_checked++;
        if (cmd_x_o !== want.cmd_x) note_mismatch("cmd_x", want.cmd_x, cmd_x_o);
        if (cmd_y_o !== want.cmd_y) note_mismatch("cmd_y", want.cmd_y, cmd_y_o);
      end
    end
  end

  // receiver: runs of always-ready, random and stalled cycles
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned span;
    out_ready_i <= 1'b0;
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(1, 120);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          SINK_OPEN:  out_ready_i <= 1'b1;
          SINK_LOOSE: out_ready_i <= ($urandom_range(0, 1) == 1);
          SINK_TIGHT: out_ready_i <= ($urandom_range(0, 7) == 0);
          default:    out_ready_i <= 1'b0;
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_SETPOINT:      setpoint_v = longint'(signed'(data));
      REG_STEP_SIZE:     step_v = longint'(data[STEP_W-1:0]);
      REG_GAIN_POSITION: gain_pos_v = longint'(signed'(data));
      REG_GAIN_VELOCITY: gain_vel_v = longint'(signed'(data));
      REG_GAIN_INTEGRAL: gain_int_v = longint'(signed'(data));
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [FIELD_W-1:0] sp, input logic [FIELD_W-1:0] st,
                               input logic [FIELD_W-1:0] kp, input logic [FIELD_W-1:0] kv,
                               input logic [FIELD_W-1:0] ki);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_STEP_SIZE, st);
    write_reg(REG_GAIN_POSITION, kp);
    write_reg(REG_GAIN_VELOCITY, kv);
    write_reg(REG_GAIN_INTEGRAL, ki);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // called right after a rising edge; returns at the edge that takes the beat, or after a random idle gap
  task automatic send_tick(input tick_t t);
    in_valid_i <= 1'b1;
    position_seen_i <= t.seen;
    pos_x_i <= t.pos_x;
    pos_y_i <= t.pos_y;
    vel_x_i <= t.vel_x;
    vel_y_i <= t.vel_y;
    ref_0_i <= t.ref_0;
    ref_1_i <= t.ref_1;
    ref_2_i <= t.ref_2;
    ref_3_i <= t.ref_3;
    do @(posedge clk_i); while (!in_ready_o);
    advance_controller(t);
    ticks_sent++;
    if (!t.seen) idle_ticks++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 180)) @(posedge clk_i);
      else repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // let all commands drain and the block go idle before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_tick(wild_tick(1'b0));
    send_tick(flat_tick(1'b1, '0));
    send_tick(make_tick(1'b1, WORD_ONE, -WORD_ONE, WORD_ONE, -WORD_ONE,
                        WORD_ONE, WORD_ONE, -WORD_ONE, WORD_ONE));
    send_tick(wild_tick(1'b0));
    send_tick(flat_tick(1'b1, WORD_MAX));
    send_tick(flat_tick(1'b1, WORD_MIN));
    send_tick(flat_tick(1'b1, WORD_MAX));
    send_tick(flat_tick(1'b1, '0));
  endtask

  task automatic test_saturation();
    settle();
    load_settings(WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    send_tick(flat_tick(1'b1, WORD_MAX));
    send_tick(flat_tick(1'b1, WORD_MIN));
    send_tick(make_tick(1'b1, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX,
                        WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
    send_tick(flat_tick(1'b1, WORD_NEG_LSB));
    send_tick(flat_tick(1'b1, WORD_MAX));
    settle();
    load_settings(WORD_MAX, '0, WORD_MIN, WORD_MIN, WORD_MIN);
    send_tick(flat_tick(1'b1, WORD_MIN));
    send_tick(flat_tick(1'b1, WORD_MAX));
    send_tick(flat_tick(1'b1, '0));
    send_tick(flat_tick(1'b1, WORD_ONE));
  endtask

  task automatic test_register_extremes();
    settle();
    // top bit of the step register is not stored; spare indexes are ignored
    write_reg(REG_STEP_SIZE, 32'hffff_ffff);
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
      write_reg(CFG_IDX_W'(i), $urandom());
    end
    cfg_we_i <= 1'b0;
    send_tick(make_tick(1'b1, span_word(20), span_word(20), span_word(18), span_word(18),
                        span_word(18), span_word(18), span_word(18), span_word(18)));
    send_tick(wild_tick(1'b1));
    send_tick(flat_tick(1'b1, WORD_ONE));
    settle();
    load_settings('0, '0, '0, '0, '0);
    send_tick(wild_tick(1'b1));
    send_tick(flat_tick(1'b1, WORD_MAX));
  endtask

  task automatic test_random_ticks();
    int unsigned seen_in_phase;
    int          traj_x, traj_y;
    logic signed [FIELD_W-1:0] dx, dy;
    traj_x = 0;
    traj_y = 0;
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      if (phase == 0) begin
        load_settings(32'sd131072, 32'sd1311, 32'sd247936, 32'sd89902, -32'sd215960);
      end else begin
        load_settings(($urandom_range(0, 3) == 0) ? $urandom() : span_word(22),
                      ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 15),
                      pick_gain(), pick_gain(), pick_gain());
      end
      seen_in_phase = 0;
      while (seen_in_phase < 140) begin
        case ($urandom_range(0, 9))
          0: send_tick(wild_tick(1'b0));
          1, 2: begin
            send_tick(wild_tick(1'b1));
            seen_in_phase++;
          end
          default: begin
            // smooth flight path with small velocities and reference states
            dx = span_word(14);
            dy = span_word(14);
            traj_x += dx;
            traj_y += dy;
            if (traj_x > (1 << 24) || traj_x < -(1 << 24)) traj_x = 0;
            if (traj_y > (1 << 24) || traj_y < -(1 << 24)) traj_y = 0;
            send_tick(make_tick(1'b1, traj_x, traj_y, span_word(18), span_word(18),
                                span_word(18), span_word(18), span_word(18), span_word(18)));
            seen_in_phase++;
          end
        endcase
      end
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    position_seen_i <= 1'b0;
    pos_x_i <= '0;
    pos_y_i <= '0;
    vel_x_i <= '0;
    vel_y_i <= '0;
    ref_0_i <= '0;
    ref_1_i <= '0;
    ref_2_i <= '0;
    ref_3_i <= '0;
    failures = 0;
    ticks_sent = 0;
    idle_ticks = 0;
    beats_checked = 0;
    settings_loaded = 0;
    burst_left = 0;
    setpoint_v = 131072;
    step_v = 1311;
    gain_pos_v = 247936;
    gain_vel_v = 89902;
    gain_int_v = -215960;
    prev_pos_x = 0;
    prev_pos_y = 0;
    prev_vel_x = 0;
    prev_vel_y = 0;
    prev_cmd_x = 0;
    prev_cmd_y = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_saturation();
    test_register_extremes();
    test_random_ticks();

    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_cmds.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_cmds.size() != 0) begin
      $display("%0d command beats never arrived", expected_cmds.size());
      failures += expected_cmds.size();
    end

    $display("sent %0d ticks (%0d without a position) under %0d register settings",
             ticks_sent, idle_ticks, settings_loaded);
    $display("checked %0d command beats, %0d failures", beats_checked, failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
